FILE: hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  // longest token is MAX_TOKEN-1 characters
  localparam int MAX_TOKEN = 20;
  localparam int LEN_W     = $clog2(MAX_TOKEN);

  // beat queue between front and back, depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [1:0] KIND_ID    = 2'd0;
  localparam logic [1:0] KIND_CONST = 2'd1;
  localparam logic [1:0] KIND_OP    = 2'd2;

  // special characters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // input op codes
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] char_out;
    logic       token_end;
    logic       run_end;
  } out_beat_t;

  // up to two result beats produced by one input beat
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  b0;
    out_beat_t  b1;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic room2;
  } q_stat_t;

endpackage

FILE: hw/rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// classifies each text byte, runs the comment and token state machine and
// produces up to two result beats per input beat
// ----------------------------------------------------------------------------
module stt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  stt_pkg::in_beat_t   in_data,
  output stt_pkg::push_t      push
);

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_SLASH = 5'b00010,
    M_LINE  = 5'b00100,
    M_BLOCK = 5'b01000,
    M_STAR  = 5'b10000
  } mode_t;

  mode_t                     mode_r, mode_nxt;
  logic                      held_valid_r, held_valid_nxt;
  logic                      held_const_r, held_const_nxt;
  logic [7:0]                held_char_r, held_char_nxt;
  logic [stt_pkg::LEN_W-1:0] len_r, len_nxt;

  logic       is_let, is_dig, is_opc, cont, fits;
  logic       do_idle;
  logic [1:0] n;
  stt_pkg::out_beat_t r0, r1, e;
  logic [7:0] c;

  function automatic stt_pkg::out_beat_t mk(input logic [1:0] k, input logic [7:0] ch,
                                            input logic te);
    stt_pkg::out_beat_t b;
    b.token_kind = k;
    b.char_out   = ch;
    b.token_end  = te;
    b.run_end    = 1'b0;
    return b;
  endfunction

  assign c      = in_data.char_byte;
  assign is_let = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_dig = (c >= 8'h30 && c <= 8'h39);
  assign is_opc = (c == stt_pkg::CH_PLUS) || (c == stt_pkg::CH_MINUS) ||
                  (c == stt_pkg::CH_STAR) || (c == stt_pkg::CH_SLASH) ||
                  (c == stt_pkg::CH_EQ)   || (c == stt_pkg::CH_LT) ||
                  (c == stt_pkg::CH_GT);
  assign cont   = held_const_r ? is_dig : (is_let || is_dig);
  assign fits   = len_r < stt_pkg::LEN_W'(stt_pkg::MAX_TOKEN - 1);

  always_comb begin
    mode_nxt       = mode_r;
    held_valid_nxt = held_valid_r;
    held_const_nxt = held_const_r;
    held_char_nxt  = held_char_r;
    len_nxt        = len_r;
    n              = 2'd0;
    r0             = '0;
    r1             = '0;
    e              = '0;
    do_idle        = 1'b0;
    if (in_fire) begin
      if (in_data.op == stt_pkg::OP_FLUSH) begin
        if (mode_r == M_SLASH) begin
          r0 = mk(stt_pkg::KIND_OP, stt_pkg::CH_SLASH, 1'b1);
          n  = 2'd1;
        end
        if (held_valid_r) begin
          e = mk({1'b0, held_const_r}, held_char_r, 1'b1);
          if (n == 2'd0) r0 = e;
          else           r1 = e;
          n = n + 2'd1;
        end
        mode_nxt       = M_IDLE;
        held_valid_nxt = 1'b0;
        held_const_nxt = 1'b0;
        held_char_nxt  = '0;
        len_nxt        = '0;
      end else begin
        unique case (mode_r)
          M_LINE: begin
            if (c == stt_pkg::CH_NL) mode_nxt = M_IDLE;
          end
          M_BLOCK: begin
            if (c == stt_pkg::CH_STAR) mode_nxt = M_STAR;
          end
          M_STAR: begin
            if (c == stt_pkg::CH_SLASH)     mode_nxt = M_IDLE;
            else if (c != stt_pkg::CH_STAR) mode_nxt = M_BLOCK;
          end
          M_SLASH: begin
            if (c == stt_pkg::CH_SLASH) begin
              mode_nxt = M_LINE;
            end else if (c == stt_pkg::CH_STAR) begin
              mode_nxt = M_BLOCK;
            end else begin
              r0       = mk(stt_pkg::KIND_OP, stt_pkg::CH_SLASH, 1'b1);
              n        = 2'd1;
              mode_nxt = M_IDLE;
              do_idle  = 1'b1;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            do_idle  = 1'b1;
          end
        endcase
        if (do_idle) begin
          if (held_valid_r && cont && fits) begin
            // token goes on, release the held character
            r0            = mk({1'b0, held_const_r}, held_char_r, 1'b0);
            n             = 2'd1;
            held_char_nxt = c;
            len_nxt       = len_r + 1'b1;
          end else begin
            if (held_valid_r) begin
              e = mk({1'b0, held_const_r}, held_char_r, 1'b1);
              if (n == 2'd0) r0 = e;
              else           r1 = e;
              n              = n + 2'd1;
              held_valid_nxt = 1'b0;
              len_nxt        = '0;
            end
            if (is_let || is_dig) begin
              held_char_nxt  = c;
              held_const_nxt = !is_let;
              held_valid_nxt = 1'b1;
              len_nxt        = stt_pkg::LEN_W'(1);
            end else if (c == stt_pkg::CH_SLASH) begin
              mode_nxt = M_SLASH;
            end else if (is_opc) begin
              e = mk(stt_pkg::KIND_OP, c, 1'b1);
              if (n == 2'd0) r0 = e;
              else           r1 = e;
              n = n + 2'd1;
            end
          end
        end
      end
    end
    // mark the last result of this input beat
    if (n == 2'd2)      r1.run_end = 1'b1;
    else if (n == 2'd1) r0.run_end = 1'b1;
    push.cnt = n;
    push.b0  = r0;
    push.b1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      held_valid_r <= 1'b0;
      len_r        <= '0;
    end else begin
      mode_r       <= mode_nxt;
      held_valid_r <= held_valid_nxt;
      len_r        <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_char_r  <= held_char_nxt;
    held_const_r <= held_const_nxt;
  end

  // a held character only exists outside comments and slash lookahead
  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> mode_r == M_IDLE)
    else $error("held character outside idle mode");

  // length counter tracks the held character
  a_len_held: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r == (len_r != '0))
    else $error("token length out of step with held character");

  // only the second of two beats closes the run
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> (push.b1.run_end && !push.b0.run_end))
    else $error("run end mark on wrong beat");

endmodule

FILE: hw/rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// small beat queue, up to two beats in and one beat out per cycle
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::push_t     push,
  input  logic               pop,
  output stt_pkg::out_beat_t head,
  output stt_pkg::q_stat_t   stat
);

  stt_pkg::out_beat_t         mem_r [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [stt_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [stt_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [stt_pkg::QPTR_W-1:0] wr_ptr1;

  assign wr_ptr1    = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + stt_pkg::QPTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + stt_pkg::QPTR_W'(pop);
  assign count_nxt  = count_r + stt_pkg::QCNT_W'(push.cnt) - stt_pkg::QCNT_W'(pop);

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.room2     = (count_r <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.b0;
    if (push.cnt == 2'd2) mem_r[wr_ptr1]  <= push.b1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH))
    else $error("beat queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> stat.room2)
    else $error("push without room for two beats");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.not_empty)
    else $error("pop from empty beat queue");

endmodule

FILE: hw/rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// result output register, refilled from the beat queue
// ----------------------------------------------------------------------------
module stt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::out_beat_t head,
  input  stt_pkg::q_stat_t   stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output stt_pkg::out_beat_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  stt_pkg::out_beat_t out_data_r;

  // load when the register is empty or its beat leaves this cycle
  assign pop           = stat.not_empty && (!out_valid_r || out_ready);
  assign out_valid_nxt = pop || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= head;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming tokenizer: text bytes in, tagged token characters out
// ----------------------------------------------------------------------------
// One text byte (or an end-of-input flush) is taken per cycle while the queue
// has room for two beats and turned into zero, one or two result beats, each
// a token character tagged identifier, constant or operator with a token end
// mark, and run_end on the last beat of an input. Letters and digits are held
// one byte so their end mark is known; tokens split after MAX_TOKEN-1
// characters; line and block comments are dropped. The front stage holds the
// lexer state and decides everything in the cycle the byte is accepted; its
// beats go into a four-beat queue, and while out_ready is high the back stage
// drains one beat per cycle through an output register. The output port moves
// one beat per cycle, so a stream where bytes give two beats runs at the
// output rate. in_ready depends only on queue fill, never on out_ready.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stt_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stt_pkg::out_beat_t out_data
);

  stt_pkg::push_t     push;
  stt_pkg::q_stat_t   q_stat;
  stt_pkg::out_beat_t q_head;
  logic               q_pop;
  logic               in_fire;

  // accept only when the queue can take the worst case of two beats
  assign in_ready = q_stat.room2;
  assign in_fire  = in_valid && in_ready;

  // front: lexer state machine and token hold
  stt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .push    (push)
  );

  // queue decouples the two sides
  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // back: output register
  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
